@@ rtl/lct_pkg.sv @@
// Shared types and constants for the minimum line tree unit.
// Used by every module of the block; depends on nothing.
package lct_pkg;

  localparam int X_BITS    = 10;
  localparam int AW        = X_BITS + 1;
  localparam int NODES     = 1 << AW;
  localparam int IDX_W     = AW + 1;
  localparam int STK_DEPTH = X_BITS + 1;
  localparam int SP_W      = $clog2(STK_DEPTH + 1);
  localparam int CW        = 33;
  localparam int VW        = 64;
  localparam int IN_DW     = 224;

  localparam logic [IDX_W-1:0] NODE_LAST = IDX_W'(NODES - 1);

  localparam logic [1:0] REQ_LINE  = 2'd0;
  localparam logic [1:0] REQ_SEG   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] CFG_DLOW  = 2'd0;
  localparam logic [1:0] CFG_DHIGH = 2'd1;
  localparam logic [1:0] CFG_EMPTY = 2'd2;

  localparam logic [VW-1:0] EMPTY_RESET = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0]   DHIGH_RESET = 32'd1023;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLR, OP_LOAD, OP_EVAL, OP_WRITE_NEW, OP_SPLIT,
    OP_PUSH_DESC, OP_POP, OP_QSTEP, OP_RES_VAL, OP_RES_OOD
  } dp_op_e;

  typedef enum logic [2:0] {
    EV_TL, EV_TR, EV_XL, EV_XR, EV_XM, EV_TM, EV_QV
  } ev_e;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DISP, ST_LCHK, ST_LRD, ST_LEV, ST_LWAIT, ST_LDEC,
    ST_SVIS, ST_SCHK, ST_SEV, ST_SWAIT, ST_SDEC, ST_SPOP,
    ST_QVIS, ST_QRD, ST_QWAIT, ST_QSTEP, ST_RVAL, ST_ROOD
  } state_e;

  typedef struct packed {
    dp_op_e op;
    ev_e    ev;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] kind;
    logic       ordered;
    logic       seg_ok;
    logic       q_ood;
    logic       node_valid;
    logic       in_range;
    logic       seg_hit;
    logic       seg_cover;
    logic       keep_old;
    logic       take_new;
    logic       leaf;
    logic       sp_empty;
    logic       q_last;
    logic       ev_idle;
    logic       out_free;
  } dp_stat_t;

  typedef struct packed {
    logic          valid;
    logic [VW-1:0] slope;
    logic [VW-1:0] icpt;
  } node_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CW-1:0]    l;
    logic [CW-1:0]    r;
  } stk_t;

endpackage

@@ rtl/lct_eval.sv @@
// Two-stage line evaluator: a*x + b, wrapping at 64 bits.
// Built from three 32x32 partial products; depends on lct_pkg.
module lct_eval (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    req_i,
  input  lct_pkg::ev_e            tag_i,
  input  logic [lct_pkg::VW-1:0]  a_i,
  input  logic [lct_pkg::VW-1:0]  b_i,
  input  logic [lct_pkg::CW-1:0]  x_i,
  output logic                    res_v_o,
  output lct_pkg::ev_e            res_tag_o,
  output logic [lct_pkg::VW-1:0]  res_o,
  output logic                    busy_o
);
  import lct_pkg::*;

  logic [VW-1:0] x64;
  logic          s1_v_q, s2_v_q;
  ev_e           s1_tag_q, s2_tag_q;
  logic [63:0]   p0_q;
  logic [31:0]   p1_q, p2_q;
  logic [VW-1:0] b1_q, y_q;
  logic [31:0]   mid;

  assign x64 = {{(VW-CW){x_i[CW-1]}}, x_i};
  assign mid = p1_q + p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= req_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= tag_i;
    p0_q     <= {32'd0, a_i[31:0]} * {32'd0, x64[31:0]};
    p1_q     <= 32'(a_i[63:32] * x64[31:0]);
    p2_q     <= 32'(a_i[31:0] * x64[63:32]);
    b1_q     <= b_i;
    s2_tag_q <= s1_tag_q;
    y_q      <= p0_q + {mid, 32'd0} + b1_q;
  end

  assign res_v_o   = s2_v_q;
  assign res_tag_o = s2_tag_q;
  assign res_o     = y_q;
  assign busy_o    = s1_v_q | s2_v_q;

endmodule

@@ rtl/lct_dp.sv @@
// Datapath: node memory, traversal registers, segment stack, result register.
// Acts on commands from lct_ctrl; depends on lct_pkg and lct_eval.
module lct_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lct_pkg::dp_cmd_t           cmd_i,
  output lct_pkg::dp_stat_t          stat_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [lct_pkg::VW-1:0]     cfg_data_i,
  input  logic [lct_pkg::IN_DW-1:0]  s_tdata_i,
  input  logic [1:0]                 s_tuser_i,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [lct_pkg::VW-1:0]     m_tdata_o,
  output logic                       m_tuser_o
);
  import lct_pkg::*;

  node_t mem [NODES];
  node_t rd_q;
  stk_t  stk [STK_DEPTH];

  logic [31:0]        dlow_q, dhigh_q;
  logic [VW-1:0]      empty_q;
  logic [AW-1:0]      clr_cnt_q;
  logic [SP_W-1:0]    sp_q;
  logic               out_v_q, found_q;
  logic [1:0]         kind_q;
  logic [IDX_W-1:0]   idx_q;
  logic signed [CW-1:0] l_q, r_q, x_q, lo_q, hi_q, m, m_p1, dl, dh;
  logic [CW:0]        diff;
  logic [VW-1:0]      la_q, lb_q, ca_q, cb_q, best_q, out_q;
  logic               ood_q;
  logic signed [VW-1:0] tl_q, tr_q, xl_q, xr_q, xm_q, tm_q, qv_q;
  logic signed [VW-1:0] lose, win;
  logic               new_wins, go_left;
  logic [IDX_W-1:0]   idx_l, idx_r;

  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  node_t              mem_wd;

  logic               ev_req, ev_res_v, ev_busy;
  ev_e                ev_res_tag;
  logic [VW-1:0]      ev_a, ev_b, ev_y;
  logic [CW-1:0]      ev_x;

  assign dl    = {dlow_q[31], dlow_q};
  assign dh    = {dhigh_q[31], dhigh_q};
  assign diff  = {r_q[CW-1], r_q} - {l_q[CW-1], l_q};
  assign m     = l_q + diff[CW:1];
  assign m_p1  = m + CW'(1);
  assign idx_l = {idx_q[IDX_W-2:0], 1'b0};
  assign idx_r = {idx_q[IDX_W-2:0], 1'b1};

  assign new_wins = xm_q < tm_q;
  assign lose     = new_wins ? tl_q : xl_q;
  assign win      = new_wins ? xl_q : tl_q;
  assign go_left  = lose <= win;

  always_comb begin
    ev_req = cmd_i.op == OP_EVAL;
    ev_a   = rd_q.slope;
    ev_b   = rd_q.icpt;
    ev_x   = l_q;
    case (cmd_i.ev)
      EV_TL: ev_x = l_q;
      EV_TR: ev_x = r_q;
      EV_TM: ev_x = m;
      EV_QV: ev_x = x_q;
      EV_XL: begin ev_a = ca_q; ev_b = cb_q; ev_x = l_q; end
      EV_XR: begin ev_a = ca_q; ev_b = cb_q; ev_x = r_q; end
      EV_XM: begin ev_a = ca_q; ev_b = cb_q; ev_x = m; end
      default: ev_x = l_q;
    endcase
  end

  lct_eval u_eval (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ev_req),
    .tag_i     (cmd_i.ev),
    .a_i       (ev_a),
    .b_i       (ev_b),
    .x_i       (ev_x),
    .res_v_o   (ev_res_v),
    .res_tag_o (ev_res_tag),
    .res_o     (ev_y),
    .busy_o    (ev_busy)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q[AW-1:0];
    mem_wd = '{valid: 1'b1, slope: ca_q, icpt: cb_q};
    case (cmd_i.op)
      OP_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_q;
        mem_wd = '0;
      end
      OP_WRITE_NEW: mem_we = 1'b1;
      OP_SPLIT:     mem_we = new_wins;
      default:      mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlow_q  <= '0;
      dhigh_q <= DHIGH_RESET;
      empty_q <= EMPTY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DLOW:  dlow_q  <= cfg_data_i[31:0];
        CFG_DHIGH: dhigh_q <= cfg_data_i[31:0];
        CFG_EMPTY: empty_q <= cfg_data_i;
        default:   empty_q <= empty_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.op == OP_RES_VAL || cmd_i.op == OP_RES_OOD) begin
      out_v_q <= 1'b1;
    end else if (m_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      sp_q      <= '0;
      found_q   <= 1'b0;
      kind_q    <= REQ_LINE;
    end else begin
      case (cmd_i.op)
        OP_CLR:       clr_cnt_q <= clr_cnt_q + AW'(1);
        OP_LOAD: begin
          kind_q  <= s_tuser_i;
          sp_q    <= '0;
          found_q <= 1'b0;
        end
        OP_PUSH_DESC: sp_q <= sp_q + SP_W'(1);
        OP_POP:       sp_q <= sp_q - SP_W'(1);
        OP_QSTEP: begin
          if (rd_q.valid) begin
            found_q <= 1'b1;
          end
        end
        default: kind_q <= kind_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_res_v) begin
      case (ev_res_tag)
        EV_TL:   tl_q <= ev_y;
        EV_TR:   tr_q <= ev_y;
        EV_XL:   xl_q <= ev_y;
        EV_XR:   xr_q <= ev_y;
        EV_XM:   xm_q <= ev_y;
        EV_TM:   tm_q <= ev_y;
        default: qv_q <= ev_y;
      endcase
    end
    case (cmd_i.op)
      OP_LOAD: begin
        la_q   <= s_tdata_i[63:0];
        ca_q   <= s_tdata_i[63:0];
        lb_q   <= s_tdata_i[127:64];
        cb_q   <= s_tdata_i[127:64];
        x_q    <= {s_tdata_i[159], s_tdata_i[159:128]};
        lo_q   <= {s_tdata_i[191], s_tdata_i[191:160]};
        hi_q   <= {s_tdata_i[223], s_tdata_i[223:192]} - CW'(1);
        idx_q  <= IDX_W'(1);
        l_q    <= dl;
        r_q    <= dh;
        best_q <= empty_q;
      end
      OP_SPLIT: begin
        if (new_wins) begin
          ca_q <= rd_q.slope;
          cb_q <= rd_q.icpt;
        end
        if (go_left) begin
          idx_q <= idx_l;
          r_q   <= m;
        end else begin
          idx_q <= idx_r;
          l_q   <= m_p1;
        end
      end
      OP_PUSH_DESC: begin
        stk[sp_q[SP_W-1:0]] <= '{idx: idx_r, l: m_p1, r: r_q};
        idx_q <= idx_l;
        r_q   <= m;
      end
      OP_POP: begin
        idx_q <= stk[sp_q - SP_W'(1)].idx;
        l_q   <= stk[sp_q - SP_W'(1)].l;
        r_q   <= stk[sp_q - SP_W'(1)].r;
        ca_q  <= la_q;
        cb_q  <= lb_q;
      end
      OP_QSTEP: begin
        if (rd_q.valid && (!found_q || (qv_q < $signed(best_q)))) begin
          best_q <= qv_q;
        end
        if (x_q <= m) begin
          idx_q <= idx_l;
          r_q   <= m;
        end else begin
          idx_q <= idx_r;
          l_q   <= m_p1;
        end
      end
      OP_RES_VAL: begin
        out_q <= best_q;
        ood_q <= 1'b0;
      end
      OP_RES_OOD: begin
        out_q <= empty_q;
        ood_q <= 1'b1;
      end
      default: out_q <= out_q;
    endcase
  end

  always_comb begin
    stat_o.clr_last   = &clr_cnt_q;
    stat_o.kind       = kind_q;
    stat_o.ordered    = $signed(dlow_q) <= $signed(dhigh_q);
    stat_o.seg_ok     = lo_q <= hi_q;
    stat_o.q_ood      = !stat_o.ordered || (x_q < dl) || (x_q > dh);
    stat_o.node_valid = rd_q.valid;
    stat_o.in_range   = (idx_q <= NODE_LAST) && (l_q <= r_q);
    stat_o.seg_hit    = stat_o.in_range && !(r_q < lo_q) && !(hi_q < l_q);
    stat_o.seg_cover  = (lo_q <= l_q) && (r_q <= hi_q);
    stat_o.keep_old   = (tl_q <= xl_q) && (tr_q <= xr_q);
    stat_o.take_new   = (xl_q <= tl_q) && (xr_q <= tr_q);
    stat_o.leaf       = l_q == r_q;
    stat_o.sp_empty   = sp_q == '0;
    stat_o.q_last     = (l_q >= r_q) || (idx_q[IDX_W-1:X_BITS] != '0);
    stat_o.ev_idle    = !ev_busy;
    stat_o.out_free   = !out_v_q || m_tready_i;
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_q;
  assign m_tuser_o  = ood_q;

`ifndef SYNTH
  a_write_in_array: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_WRITE_NEW || cmd_i.op == OP_SPLIT) |-> idx_q <= NODE_LAST)
    else $error("node write beyond array");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_PUSH_DESC |-> sp_q < SP_W'(STK_DEPTH))
    else $error("segment stack overflow");
  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_RES_VAL || cmd_i.op == OP_RES_OOD) |-> (!out_v_q || m_tready_i))
    else $error("result overwrites pending transfer");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_POP |-> sp_q != '0)
    else $error("pop from empty stack");
`endif

endmodule

@@ rtl/lct_ctrl.sv @@
// Controller: sequences clear pass, line insert, segment walk and query.
// Drives lct_dp by command; depends on lct_pkg.
module lct_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  lct_pkg::dp_stat_t  stat_i,
  output lct_pkg::dp_cmd_t   cmd_o
);
  import lct_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  state_e     done_st;

  assign done_st = (stat_i.kind == REQ_SEG) ? ST_SPOP : ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    s_tready_o = 1'b0;
    cmd_o      = '{op: OP_NONE, ev: ev_e'(cnt_q)};
    case (state_q)
      ST_CLR: begin
        cmd_o.op = OP_CLR;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISP;
        end
      end
      ST_DISP: begin
        case (stat_i.kind)
          REQ_LINE:  state_d = stat_i.ordered ? ST_LCHK : ST_IDLE;
          REQ_SEG:   state_d = (stat_i.ordered && stat_i.seg_ok) ? ST_SVIS : ST_IDLE;
          REQ_QUERY: state_d = stat_i.q_ood ? ST_ROOD : ST_QRD;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_LCHK: state_d = stat_i.in_range ? ST_LRD : done_st;
      ST_LRD: begin
        if (!stat_i.node_valid) begin
          cmd_o.op = OP_WRITE_NEW;
          state_d  = done_st;
        end else begin
          cnt_d   = '0;
          state_d = ST_LEV;
        end
      end
      ST_LEV: begin
        cmd_o.op = OP_EVAL;
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == 3'(EV_TM)) state_d = ST_LWAIT;
      end
      ST_LWAIT: if (stat_i.ev_idle) state_d = ST_LDEC;
      ST_LDEC: begin
        if (stat_i.keep_old) begin
          state_d = done_st;
        end else if (stat_i.take_new) begin
          cmd_o.op = OP_WRITE_NEW;
          state_d  = done_st;
        end else begin
          cmd_o.op = OP_SPLIT;
          state_d  = ST_LCHK;
        end
      end
      ST_SVIS: state_d = ST_SCHK;
      ST_SCHK: begin
        cnt_d = '0;
        if (!stat_i.seg_hit) state_d = ST_SPOP;
        else if (stat_i.seg_cover) state_d = ST_LRD;
        else if (stat_i.node_valid) state_d = ST_SEV;
        else state_d = ST_SDEC;
      end
      ST_SEV: begin
        cmd_o.op = OP_EVAL;
        cnt_d    = cnt_q + 3'd1;
        if (cnt_q == 3'(EV_XR)) state_d = ST_SWAIT;
      end
      ST_SWAIT: if (stat_i.ev_idle) state_d = ST_SDEC;
      ST_SDEC: begin
        if ((stat_i.node_valid && stat_i.keep_old) || stat_i.leaf) begin
          state_d = ST_SPOP;
        end else begin
          cmd_o.op = OP_PUSH_DESC;
          state_d  = ST_SVIS;
        end
      end
      ST_SPOP: begin
        if (stat_i.sp_empty) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.op = OP_POP;
          state_d  = ST_SVIS;
        end
      end
      ST_QVIS: state_d = ST_QRD;
      ST_QRD: begin
        if (stat_i.node_valid) begin
          cmd_o.op = OP_EVAL;
          cmd_o.ev = EV_QV;
          state_d  = ST_QWAIT;
        end else begin
          state_d = ST_QSTEP;
        end
      end
      ST_QWAIT: if (stat_i.ev_idle) state_d = ST_QSTEP;
      ST_QSTEP: begin
        cmd_o.op = OP_QSTEP;
        state_d  = stat_i.q_last ? ST_RVAL : ST_QVIS;
      end
      ST_RVAL: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_RES_VAL;
          state_d  = ST_IDLE;
        end
      end
      ST_ROOD: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_RES_OOD;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/li_chao_min_line_tree_unit.sv @@
// Top level of the minimum line tree unit: controller plus datapath.
// Depends on lct_pkg, lct_ctrl, lct_dp.
//
//   channel  | direction | contents
//   s_axis   | in        | tuser: req_type; tdata: slope, intercept, query_point,
//            |           |   seg_low, seg_end
//   m_axis   | out       | tdata: min_value; tuser: out_of_domain
//   cfg      | in        | write of domain_low, domain_high, empty_value
//
// After reset a clearing pass runs over the whole node memory; no input
// transfer is taken then. One item at a time: each tree level costs a
// registered memory read plus up to six line evaluations through a
// two-stage multiplier. A waiting result stalls only the next query's
// final step.
module li_chao_min_line_tree_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [lct_pkg::IN_DW-1:0] s_axis_tdata,  // slope, intercept, query_point, seg_low, seg_end
  input  logic [1:0]                s_axis_tuser,  // req_type
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [lct_pkg::VW-1:0]    m_axis_tdata,  // min_value
  output logic [0:0]                m_axis_tuser,  // out_of_domain
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [lct_pkg::VW-1:0]    cfg_data_i
);
  import lct_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lct_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser[0])
  );

endmodule
